// ===== design/rtpp_pkg.sv =====
// Shared types and constants for the RTP H.264/G.711 packetizer.
`default_nettype none

package rtpp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL       = 3'd5;

    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1400;
    localparam logic [10:0] MAX_PAYLOAD_MIN = 11'd2;
    localparam logic [6:0]  VIDEO_PT_RST    = 7'd96;
    localparam logic [6:0]  AUDIO_PT        = 7'd0;

    // Packet constants
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  PREFIX_MAGIC     = 8'h24;  // '$'
    localparam logic [7:0]  NRI_MASK         = 8'he0;
    localparam logic [7:0]  TYPE_MASK        = 8'h1f;
    localparam logic [7:0]  FU_A_TYPE        = 8'h1c;
    localparam logic [7:0]  FU_START         = 8'h80;
    localparam logic [7:0]  FU_END           = 8'h40;
    localparam logic [15:0] RTP_HDR_LEN      = 16'd12;
    localparam logic [15:0] FU_PKT_OVERHEAD  = 16'd14;
    localparam logic [10:0] AUDIO_SKIP       = 11'd3;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    typedef struct packed {
        logic        payload_mode;
        logic [31:0] ssrc;
        logic [10:0] max_payload;
        logic [6:0]  video_pt;
        logic        interleaved;
        logic [7:0]  channel;
    } t_cfg;

    // One command = all result bytes caused by one input byte
    typedef struct packed {
        logic        hdr;        // emit (prefix +) RTP header
        logic        marker;
        logic [6:0]  pt;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [15:0] size;       // packet size for the interleave prefix
        logic        hdr_last;   // header-only packet
        logic        fu;         // emit FU indicator and FU header
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic        data_en;
        logic [7:0]  data;
        logic        data_last;
    } t_cmd;

    typedef enum logic [4:0] {
        ST_DOLLAR,
        ST_CHAN,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_VER,
        ST_MPT,
        ST_SEQ_HI,
        ST_SEQ_LO,
        ST_TS3,
        ST_TS2,
        ST_TS1,
        ST_TS0,
        ST_SSRC3,
        ST_SSRC2,
        ST_SSRC1,
        ST_SSRC0,
        ST_FU_IND,
        ST_FU_HDR,
        ST_DATA
    } t_step;

endpackage

`default_nettype wire

// ===== design/rtpp_front.sv =====
// Front end: tracks frame/packet state per input byte and issues emit commands.
`default_nettype none

module rtpp_front #(
    parameter int FRAME_LENGTH_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rtpp_pkg::t_cfg               i_cfg,
    input  wire logic                         i_accept,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_frame_start,
    input  wire logic [FRAME_LENGTH_BITS-1:0] i_frame_length,
    input  wire logic [31:0]                  i_frame_time,
    output logic                              o_push,
    output rtpp_pkg::t_cmd                    o_cmd
);
    import rtpp_pkg::*;

    localparam int FLB   = FRAME_LENGTH_BITS;
    localparam int SUM_W = ((FLB > 16) ? FLB : 16) + 1;

    logic [15:0]    r_seq, n_seq;
    logic [31:0]    r_ts, n_ts;
    logic [FLB-1:0] r_frame_left, n_frame_left;
    logic [10:0]    r_pkt_left, n_pkt_left;
    logic [7:0]     r_nal, n_nal;
    logic           r_frag, n_frag;

    logic [10:0]    mp;
    logic [FLB-1:0] mp_ext;
    logic [FLB-1:0] flen;
    logic [FLB-1:0] pay;
    logic [SUM_W-1:0] audio_sum;
    logic [31:0]    ts_audio, ts_video;
    logic           fits;
    logic           r_gt;
    logic [10:0]    mid_size;
    logic [10:0]    pkt_eff;
    logic           push_req;
    t_cmd           cmd;

    always_comb begin
        mp        = (i_cfg.max_payload < MAX_PAYLOAD_MIN) ? MAX_PAYLOAD_MIN : i_cfg.max_payload;
        mp_ext    = {{(FLB-11){1'b0}}, mp};
        flen      = (i_frame_length == '0) ? FLB'(1) : i_frame_length;
        pay       = (flen > FLB'(4)) ? flen - FLB'(4) : '0;
        audio_sum = SUM_W'(pay) + SUM_W'(RTP_HDR_LEN);
        ts_audio  = {i_frame_time[28:0], 3'b000};
        ts_video  = i_frame_time * 32'd90;
        fits      = flen <= mp_ext;
        r_gt      = r_frame_left > mp_ext;
        mid_size  = r_gt ? mp : r_frame_left[10:0];
    end

    always_comb begin
        n_seq        = r_seq;
        n_ts         = r_ts;
        n_frame_left = r_frame_left;
        n_pkt_left   = r_pkt_left;
        n_nal        = r_nal;
        n_frag       = r_frag;
        push_req     = 1'b0;
        pkt_eff      = r_pkt_left;

        cmd           = '0;
        cmd.pt        = i_cfg.video_pt;
        cmd.seq       = r_seq;
        cmd.ts        = r_ts;
        cmd.data      = i_data_byte;

        if (i_frame_start) begin
            push_req     = 1'b1;
            n_frame_left = flen - FLB'(1);
            cmd.hdr      = 1'b1;
            if (i_cfg.payload_mode) begin
                n_ts         = ts_audio;
                cmd.ts       = ts_audio;
                cmd.marker   = 1'b1;
                cmd.pt       = AUDIO_PT;
                cmd.size     = audio_sum[15:0];
                cmd.hdr_last = (pay == '0);
                n_pkt_left   = AUDIO_SKIP;
                n_frag       = 1'b0;
            end else begin
                n_ts    = ts_video;
                cmd.ts  = ts_video;
                n_nal   = i_data_byte;
                if (fits) begin
                    cmd.marker    = 1'b1;
                    cmd.size      = RTP_HDR_LEN + 16'(flen[10:0]);
                    cmd.data_en   = 1'b1;
                    cmd.data_last = (flen == FLB'(1));
                    n_pkt_left    = flen[10:0] - 11'd1;
                    n_frag        = 1'b0;
                end else begin
                    cmd.size   = FU_PKT_OVERHEAD + 16'(mp) - 16'd1;
                    cmd.fu     = 1'b1;
                    cmd.fu_ind = (i_data_byte & NRI_MASK) | FU_A_TYPE;
                    cmd.fu_hdr = FU_START | (i_data_byte & TYPE_MASK);
                    n_pkt_left = mp - 11'd1;
                    n_frag     = 1'b1;
                end
            end
        end else if (r_frame_left != '0) begin
            n_frame_left = r_frame_left - FLB'(1);
            if (i_cfg.payload_mode) begin
                if (r_pkt_left != '0) begin
                    // audio bytes still being dropped
                    n_pkt_left = r_pkt_left - 11'd1;
                end else begin
                    push_req      = 1'b1;
                    cmd.data_en   = 1'b1;
                    cmd.data_last = (r_frame_left == FLB'(1));
                end
            end else begin
                push_req    = 1'b1;
                cmd.data_en = 1'b1;
                if (r_pkt_left == '0 && r_frag) begin
                    // next FU-A fragment opens here
                    cmd.hdr    = 1'b1;
                    cmd.marker = !r_gt;
                    cmd.size   = FU_PKT_OVERHEAD + 16'(mid_size);
                    cmd.fu     = 1'b1;
                    cmd.fu_ind = (r_nal & NRI_MASK) | FU_A_TYPE;
                    cmd.fu_hdr = r_gt ? (r_nal & TYPE_MASK)
                                      : (FU_END | (r_nal & TYPE_MASK));
                    pkt_eff    = mid_size;
                end
                if (pkt_eff != '0) begin
                    n_pkt_left    = pkt_eff - 11'd1;
                    cmd.data_last = (pkt_eff == 11'd1);
                end else begin
                    n_pkt_left    = pkt_eff;
                    cmd.data_last = (r_frame_left == FLB'(1));
                end
            end
        end

        if (cmd.hdr) begin
            n_seq = r_seq + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= '0;
            r_ts         <= '0;
            r_frame_left <= '0;
            r_pkt_left   <= '0;
            r_nal        <= '0;
            r_frag       <= 1'b0;
        end else if (i_accept) begin
            r_seq        <= n_seq;
            r_ts         <= n_ts;
            r_frame_left <= n_frame_left;
            r_pkt_left   <= n_pkt_left;
            r_nal        <= n_nal;
            r_frag       <= n_frag;
        end
    end

    assign o_push = i_accept && push_req;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

// ===== design/rtpp_cmd_fifo.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module rtpp_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rtpp_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output rtpp_pkg::t_cmd      o_cmd
);
    import rtpp_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== design/rtpp_back.sv =====
// Back end: expands each command into packet bytes behind an output register.
`default_nettype none

module rtpp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rtpp_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire rtpp_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    input  wire logic           i_out_pop,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_packet_last,
    output logic                o_run_last
);
    import rtpp_pkg::*;

    t_step      r_step;
    logic       r_active;
    t_step      first_step, cur, nxt;
    logic       is_last;
    logic       adv;
    logic [7:0] byte_val;
    logic       pkt_last;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_packet_last;
    logic       r_run_last;

    // step sequencing
    always_comb begin
        if (i_cmd.hdr) begin
            first_step = i_cfg.interleaved ? ST_DOLLAR : ST_VER;
        end else begin
            first_step = ST_DATA;
        end
        cur = r_active ? r_step : first_step;
        case (cur)
            ST_SSRC0:  nxt = i_cmd.fu ? ST_FU_IND : ST_DATA;
            ST_FU_HDR: nxt = ST_DATA;
            ST_DATA:   nxt = ST_DATA;
            default:   nxt = t_step'(cur + 5'd1);
        endcase
        is_last = (cur == ST_DATA)
               || (cur == ST_SSRC0 && !i_cmd.fu && !i_cmd.data_en)
               || (cur == ST_FU_HDR && !i_cmd.data_en);
    end

    // byte selection
    always_comb begin
        case (cur)
            ST_DOLLAR:  byte_val = PREFIX_MAGIC;
            ST_CHAN:    byte_val = i_cfg.channel;
            ST_LEN_HI:  byte_val = i_cmd.size[15:8];
            ST_LEN_LO:  byte_val = i_cmd.size[7:0];
            ST_VER:     byte_val = RTP_VERSION_BYTE;
            ST_MPT:     byte_val = {i_cmd.marker, i_cmd.pt};
            ST_SEQ_HI:  byte_val = i_cmd.seq[15:8];
            ST_SEQ_LO:  byte_val = i_cmd.seq[7:0];
            ST_TS3:     byte_val = i_cmd.ts[31:24];
            ST_TS2:     byte_val = i_cmd.ts[23:16];
            ST_TS1:     byte_val = i_cmd.ts[15:8];
            ST_TS0:     byte_val = i_cmd.ts[7:0];
            ST_SSRC3:   byte_val = i_cfg.ssrc[31:24];
            ST_SSRC2:   byte_val = i_cfg.ssrc[23:16];
            ST_SSRC1:   byte_val = i_cfg.ssrc[15:8];
            ST_SSRC0:   byte_val = i_cfg.ssrc[7:0];
            ST_FU_IND:  byte_val = i_cmd.fu_ind;
            ST_FU_HDR:  byte_val = i_cmd.fu_hdr;
            ST_DATA:    byte_val = i_cmd.data;
            default:    byte_val = i_cmd.data;
        endcase
        pkt_last = (cur == ST_SSRC0 && i_cmd.hdr_last)
                || (cur == ST_DATA && i_cmd.data_last);
    end

    assign adv       = i_cmd_valid && (!r_out_valid || i_out_pop);
    assign o_cmd_pop = adv && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_DATA;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_step      <= nxt;
            r_active    <= !is_last;
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte    <= byte_val;
            r_packet_last <= pkt_last;
            r_run_last    <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_packet_last = r_packet_last;
    assign o_run_last    = r_run_last;

endmodule

`default_nettype wire

// ===== design/rtp_h264_g711_packetizer.sv =====
// Top level of the RTP H.264 (FU-A) / G.711 packetizer.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------------
//  input     | push / full         | i_data_byte, i_frame_start, i_frame_length,
//            |                     | i_frame_time
//  result    | empty / pop         | o_out_byte, o_packet_last, o_run_last
//  config    | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One input request is taken per cycle while the command queue has room; one result
// byte leaves per cycle while the receiver pops. A request yields 0 to 19 bytes; the
// byte sequencer emits one byte a cycle unless stalled, so the extra header bytes of a
// packet start are absorbed by the 4-entry command queue and then by full.
// Synchronous active-low reset clears queue and counters and loads the configuration defaults; no clear pass.
// Either side may stall freely; the output register holds its byte until popped.
`default_nettype none

module rtp_h264_g711_packetizer #(
    parameter int FRAME_LENGTH_BITS = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_frame_start,
    input  wire logic [FRAME_LENGTH_BITS-1:0]       i_frame_length,
    input  wire logic [31:0]                        i_frame_time,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [7:0]                              o_out_byte,
    output logic                                    o_packet_last,
    output logic                                    o_run_last,
    input  wire logic                               i_cfg_we,
    input  wire logic [rtpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rtpp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rtpp_pkg::*;

    t_cfg r_cfg;
    logic accept;
    logic cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd front_cmd, head_cmd;
    logic out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_mode <= 1'b0;
            r_cfg.ssrc         <= '0;
            r_cfg.max_payload  <= MAX_PAYLOAD_RST;
            r_cfg.video_pt     <= VIDEO_PT_RST;
            r_cfg.interleaved  <= 1'b0;
            r_cfg.channel      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAYLOAD_MODE: r_cfg.payload_mode <= i_cfg_data[0];
                CFG_SSRC:         r_cfg.ssrc         <= i_cfg_data;
                CFG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg_data[10:0];
                CFG_VIDEO_PT:     r_cfg.video_pt     <= i_cfg_data[6:0];
                CFG_INTERLEAVED:  r_cfg.interleaved  <= i_cfg_data[0];
                CFG_CHANNEL:      r_cfg.channel      <= i_cfg_data[7:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign accept = push && !cmd_full;

    rtpp_front #(
        .FRAME_LENGTH_BITS (FRAME_LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .i_frame_length (i_frame_length),
        .i_frame_time   (i_frame_time),
        .o_push         (cmd_push),
        .o_cmd          (front_cmd)
    );

    rtpp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_cmd   (head_cmd)
    );

    rtpp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (!cmd_empty),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (cmd_pop),
        .i_out_pop     (pop),
        .o_out_valid   (out_valid),
        .o_out_byte    (o_out_byte),
        .o_packet_last (o_packet_last),
        .o_run_last    (o_run_last)
    );

    assign full  = cmd_full;
    assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== design/rtpp_checker.sv =====
// Port-level checks for the packetizer, bound to the top level.
`default_nettype none

module rtpp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_packet_last,
    input wire logic       o_run_last
);

    // reset drains both sides
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue not drained after reset");

    // a full command queue means the sequencer is already presenting a byte
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full while output register empty");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
                              && $stable(o_packet_last) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind rtp_h264_g711_packetizer rtpp_checker u_rtpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_packet_last (o_packet_last),
    .o_run_last    (o_run_last)
);

`default_nettype wire
